/* sv/cpt_pkg.sv */
// Shared types and constants for the closest-point-on-triangle pipeline.
// No dependencies; imported by the multiplier and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

  // Width of one operand slice in the pipelined multiplier.
  localparam int LIMB_W = 32;

  // Register ranks through cpt_mul, from operand to product.
  localparam int MUL_LAT = 5;

  // How the two quotients map onto the barycentric parameters s and t.
  typedef enum logic [1:0] {
    MD_S_ONLY, // s from lane one, t is zero
    MD_T_ONLY, // t from lane one, s is zero
    MD_BOTH,   // s from lane one, t from lane two
    MD_EDGE    // s from lane one, t is one minus s
  } mode_t;

endpackage : cpt_pkg

`default_nettype wire

/* sv/cpt_pipe.sv */
// Delay line of register ranks with a shared advance enable.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cpt_pipe #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] d,
  output logic      [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule : cpt_pipe

`default_nettype wire

/* sv/cpt_mul.sv */
// Pipelined signed multiplier built from LIMB_W x LIMB_W partial products.
// Depends on cpt_pkg for the slice width.
`timescale 1ns / 1ps
`default_nettype none

module cpt_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);
  import cpt_pkg::*;

  localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
  localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
  localparam int PW = AW + BW;
  localparam int RW = (NB + 1) * LIMB_W;
  localparam int SW = (NA + NB) * LIMB_W;

  logic [AW-1:0]          ma_r;
  logic [BW-1:0]          mb_r;
  logic                   neg1_r, neg2_r, neg3_r, neg4_r;
  logic [NA*LIMB_W-1:0]   pa;
  logic [NB*LIMB_W-1:0]   pb;
  logic [2*LIMB_W-1:0]    pp_r [NA][NB];
  logic [RW-1:0]          row_nxt [NA];
  logic [RW-1:0]          row_r [NA];
  logic [SW-1:0]          sum_nxt;
  logic [PW-1:0]          mag_r;
  logic signed [PW-1:0]   p_r;

  assign pa = (NA*LIMB_W)'(ma_r);
  assign pb = (NB*LIMB_W)'(mb_r);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (RW'(pp_r[i][j]) << (j * LIMB_W));
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      sum_nxt = sum_nxt + (SW'(row_r[i]) << (i * LIMB_W));
    end
  end

  // Sign and magnitude: the magnitudes are multiplied unsigned and the sign
  // is put back in the last rank.
  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= a[AW-1] ? AW'(-a) : AW'(a);
      mb_r   <= b[BW-1] ? BW'(-b) : BW'(b);
      neg1_r <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= (2*LIMB_W)'(pa[i*LIMB_W +: LIMB_W]) *
                        (2*LIMB_W)'(pb[j*LIMB_W +: LIMB_W]);
        end
      end
      neg2_r <= neg1_r;
      row_r  <= row_nxt;
      neg3_r <= neg2_r;
      mag_r  <= sum_nxt[PW-1:0];
      neg4_r <= neg3_r;
      p_r    <= neg4_r ? -signed'(mag_r) : signed'(mag_r);
    end
  end

  assign p = p_r;

endmodule : cpt_mul

`default_nettype wire

/* sv/cpt_div.sv */
// Pipelined restoring divider giving a quotient clamped to [0,1] with FB
// fraction bits; one quotient bit per rank.
`timescale 1ns / 1ps
`default_nettype none

module cpt_div #(
  parameter int NW = 138,
  parameter int FB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [NW-1:0] num,
  input  wire logic signed [NW-1:0] den,
  output logic [FB:0]               q,
  output logic                      dz
);

  logic signed [NW-1:0] n0_r, d0_r;
  logic                 dz0_r;

  logic [NW-1:0] rem_r  [FB+1];
  logic [NW-1:0] dv_r   [FB+1];
  logic [FB-1:0] qa_r   [FB+1];
  logic          zero_r [FB+1];
  logic          one_r  [FB+1];
  logic          dz_r   [FB+1];

  logic [FB:0] q_r;
  logic        dzo_r;

  // Normalise to a positive divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      dz0_r <= (den == '0);
      if (den[NW-1]) begin
        n0_r <= -num;
        d0_r <= -den;
      end else begin
        n0_r <= num;
        d0_r <= den;
      end
    end
  end

  // Settle the clamped cases; the remainder is only meaningful when neither
  // zero nor one applies, and then it is below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= dz0_r || n0_r[NW-1] || (n0_r == '0);
      one_r[0]  <= !(dz0_r || n0_r[NW-1] || (n0_r == '0)) && (n0_r >= d0_r);
      dz_r[0]   <= dz0_r;
      rem_r[0]  <= NW'(unsigned'(n0_r));
      dv_r[0]   <= NW'(unsigned'(d0_r));
      qa_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < FB; k++) begin : g_step
    logic [NW:0]   dbl;
    logic [NW:0]   diff;
    logic          take;

    assign dbl  = {rem_r[k], 1'b0};
    assign diff = dbl - {1'b0, dv_r[k]};
    assign take = (dbl >= {1'b0, dv_r[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= take ? diff[NW-1:0] : dbl[NW-1:0];
        dv_r[k+1]   <= dv_r[k];
        qa_r[k+1]   <= {qa_r[k][FB-2:0], take};
        zero_r[k+1] <= zero_r[k];
        one_r[k+1]  <= one_r[k];
        dz_r[k+1]   <= dz_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[FB]) begin
        q_r <= '0;
      end else if (one_r[FB]) begin
        q_r <= {1'b1, {FB{1'b0}}};
      end else begin
        q_r <= {1'b0, qa_r[FB]};
      end
      dzo_r <= dz_r[FB];
    end
  end

  assign q  = q_r;
  assign dz = dzo_r;

endmodule : cpt_div

`default_nettype wire

/* sv/closest_point_on_triangle.sv */
// Top level of the closest-point-on-triangle pipeline.
// Depends on cpt_pkg, cpt_pipe, cpt_mul and cpt_div.
//
// Usage:
//   The input channel (in_valid / in_ready) carries one query per transaction:
//   a point and three triangle vertices, signed fixed point with FRAC_BITS
//   fraction bits. The result channel (out_valid / out_ready) returns the
//   nearest point on the triangle, saturated, and a degenerate flag that is
//   set when a divisor was zero and its quotient was forced to zero.
//   Exactly one result leaves for every transaction accepted, in order.
//   The datapath runs through three chained multiplier pipelines and the
//   divider, which produces one quotient bit per rank. A new transaction
//   is taken every cycle while the receiver does not stall the output.
//   When the receiver stalls with a result waiting, every rank holds and
//   in_ready falls in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits, so the pipeline comes up empty.
`timescale 1ns / 1ps
`default_nettype none

module closest_point_on_triangle #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_vert_a_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_vert_a_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_vert_a_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_vert_b_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_vert_b_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_vert_b_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_vert_c_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_vert_c_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_vert_c_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_near_x,
  output logic signed [COORD_WIDTH-1:0]      out_near_y,
  output logic signed [COORD_WIDTH-1:0]      out_near_z,
  output logic                               out_degenerate
);
  import cpt_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int ML  = MUL_LAT;
  localparam int DL  = F + 3;
  localparam int EW  = W + 1;        // edge and offset vectors
  localparam int PW1 = 2 * EW;       // one product of a dot product
  localparam int DW  = 2 * W + 4;    // dot products
  localparam int PW2 = 2 * DW;
  localparam int XW  = PW2 + 1;      // det, s, t
  localparam int NW  = XW + 1;       // divider operands
  localparam int MW  = EW + F + 2;   // edge times parameter
  localparam int AW  = MW + 1;
  localparam int VW  = W + 5;
  localparam int LAT = 3 * ML + DL + 7;
  localparam int D_E  = 2 * ML + DL + 4;
  localparam int D_VA = 3 * ML + DL + 5;
  localparam logic [AW-1:0] RND = AW'(1) << (F - 1);

  logic en;
  logic vld_r [LAT];

  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // ---- input rank: edges and offset from the query point
  logic signed [W-1:0]  pin [3], ain [3], bin [3], cin [3];
  logic signed [EW-1:0] e0_r [3], e1_r [3], dv_r [3];
  logic signed [W-1:0]  va_r [3];

  assign pin[0] = in_point_x;
  assign pin[1] = in_point_y;
  assign pin[2] = in_point_z;
  assign ain[0] = in_vert_a_x;
  assign ain[1] = in_vert_a_y;
  assign ain[2] = in_vert_a_z;
  assign bin[0] = in_vert_b_x;
  assign bin[1] = in_vert_b_y;
  assign bin[2] = in_vert_b_z;
  assign cin[0] = in_vert_c_x;
  assign cin[1] = in_vert_c_y;
  assign cin[2] = in_vert_c_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e0_r[k] <= EW'(bin[k]) - EW'(ain[k]);
        e1_r[k] <= EW'(cin[k]) - EW'(ain[k]);
        dv_r[k] <= EW'(ain[k]) - EW'(pin[k]);
        va_r[k] <= ain[k];
      end
    end
  end

  // ---- dot products
  logic signed [PW1-1:0] pa_w [3], pb_w [3], pc_w [3], pd_w [3], pe_w [3];

  for (genvar k = 0; k < 3; k++) begin : g_dot
    cpt_mul #(.AW(EW), .BW(EW)) u_maa (
      .clk(clk), .en(en), .a(e0_r[k]), .b(e0_r[k]), .p(pa_w[k]));
    cpt_mul #(.AW(EW), .BW(EW)) u_mab (
      .clk(clk), .en(en), .a(e0_r[k]), .b(e1_r[k]), .p(pb_w[k]));
    cpt_mul #(.AW(EW), .BW(EW)) u_mcc (
      .clk(clk), .en(en), .a(e1_r[k]), .b(e1_r[k]), .p(pc_w[k]));
    cpt_mul #(.AW(EW), .BW(EW)) u_mad (
      .clk(clk), .en(en), .a(e0_r[k]), .b(dv_r[k]), .p(pd_w[k]));
    cpt_mul #(.AW(EW), .BW(EW)) u_mae (
      .clk(clk), .en(en), .a(e1_r[k]), .b(dv_r[k]), .p(pe_w[k]));
  end

  logic signed [DW-1:0] a_r, b_r, c_r, d_r, e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= DW'(pa_w[0]) + DW'(pa_w[1]) + DW'(pa_w[2]);
      b_r <= DW'(pb_w[0]) + DW'(pb_w[1]) + DW'(pb_w[2]);
      c_r <= DW'(pc_w[0]) + DW'(pc_w[1]) + DW'(pc_w[2]);
      d_r <= DW'(pd_w[0]) + DW'(pd_w[1]) + DW'(pd_w[2]);
      e_r <= DW'(pe_w[0]) + DW'(pe_w[1]) + DW'(pe_w[2]);
    end
  end

  // ---- second-order products, with the dot products kept alongside
  logic signed [PW2-1:0] ac_w, bb_w, be_w, cd_w, bd_w, ae_w;

  cpt_mul #(.AW(DW), .BW(DW)) u_mac (
    .clk(clk), .en(en), .a(a_r), .b(c_r), .p(ac_w));
  cpt_mul #(.AW(DW), .BW(DW)) u_mbb (
    .clk(clk), .en(en), .a(b_r), .b(b_r), .p(bb_w));
  cpt_mul #(.AW(DW), .BW(DW)) u_mbe (
    .clk(clk), .en(en), .a(b_r), .b(e_r), .p(be_w));
  cpt_mul #(.AW(DW), .BW(DW)) u_mcd (
    .clk(clk), .en(en), .a(c_r), .b(d_r), .p(cd_w));
  cpt_mul #(.AW(DW), .BW(DW)) u_mbd (
    .clk(clk), .en(en), .a(b_r), .b(d_r), .p(bd_w));
  cpt_mul #(.AW(DW), .BW(DW)) u_mae2 (
    .clk(clk), .en(en), .a(a_r), .b(e_r), .p(ae_w));

  logic [5*DW-1:0]      dot_q;
  logic signed [DW-1:0] ad, bd, cd, dd, ed;

  cpt_pipe #(.WIDTH(5*DW), .DEPTH(ML)) u_dot_dly (
    .clk(clk), .en(en), .d({a_r, b_r, c_r, d_r, e_r}), .q(dot_q));

  assign ad = signed'(dot_q[5*DW-1:4*DW]);
  assign bd = signed'(dot_q[4*DW-1:3*DW]);
  assign cd = signed'(dot_q[3*DW-1:2*DW]);
  assign dd = signed'(dot_q[2*DW-1:DW]);
  assign ed = signed'(dot_q[DW-1:0]);

  logic signed [XW-1:0]   det_r, s_r, t_r;
  logic signed [DW-1:0]   a3_r, c3_r;
  logic signed [DW:0]     nd_r, ne_r;
  logic signed [DW+1:0]   enum_r, eden_r;
  logic                   bdce_r, bead_r, dneg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= XW'(ac_w) - XW'(bb_w);
      s_r    <= XW'(be_w) - XW'(cd_w);
      t_r    <= XW'(bd_w) - XW'(ae_w);
      a3_r   <= ad;
      c3_r   <= cd;
      nd_r   <= -(DW+1)'(dd);
      ne_r   <= -(DW+1)'(ed);
      enum_r <= ((DW+2)'(cd) + (DW+2)'(ed)) - ((DW+2)'(bd) + (DW+2)'(dd));
      eden_r <= ((DW+2)'(ad) + (DW+2)'(cd)) - ((DW+2)'(bd) + (DW+2)'(bd));
      bdce_r <= ((DW+1)'(bd) + (DW+1)'(dd)) < ((DW+1)'(cd) + (DW+1)'(ed));
      bead_r <= ((DW+1)'(bd) + (DW+1)'(ed)) < ((DW+1)'(ad) + (DW+1)'(dd));
      dneg_r <= dd[DW-1];
    end
  end

  // ---- region choice: pick what lane one divides, and how s and t follow
  logic signed [XW:0]   st_sum;
  logic                 interior;
  logic signed [NW-1:0] n1_nxt, d1_nxt;
  mode_t                mode_nxt;

  assign st_sum   = (XW+1)'(s_r) + (XW+1)'(t_r);
  assign interior = st_sum < (XW+1)'(det_r);

  always_comb begin
    n1_nxt   = NW'(nd_r);
    d1_nxt   = NW'(a3_r);
    mode_nxt = MD_S_ONLY;
    priority if (interior) begin
      if (s_r[XW-1]) begin
        if (t_r[XW-1] && dneg_r) begin
          mode_nxt = MD_S_ONLY;
        end else begin
          n1_nxt   = NW'(ne_r);
          d1_nxt   = NW'(c3_r);
          mode_nxt = MD_T_ONLY;
        end
      end else if (t_r[XW-1]) begin
        mode_nxt = MD_S_ONLY;
      end else begin
        n1_nxt   = NW'(s_r);
        d1_nxt   = NW'(det_r);
        mode_nxt = MD_BOTH;
      end
    end else begin
      if (s_r[XW-1]) begin
        if (bdce_r) begin
          n1_nxt   = NW'(enum_r);
          d1_nxt   = NW'(eden_r);
          mode_nxt = MD_EDGE;
        end else begin
          n1_nxt   = NW'(ne_r);
          d1_nxt   = NW'(c3_r);
          mode_nxt = MD_T_ONLY;
        end
      end else if (t_r[XW-1] && !bead_r) begin
        mode_nxt = MD_S_ONLY;
      end else begin
        n1_nxt   = NW'(enum_r);
        d1_nxt   = NW'(eden_r);
        mode_nxt = MD_EDGE;
      end
    end
  end

  logic signed [NW-1:0] n1_r, d1_r, n2_r, d2_r;
  mode_t                mode_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r   <= n1_nxt;
      d1_r   <= d1_nxt;
      n2_r   <= NW'(t_r);
      d2_r   <= NW'(det_r);
      mode_r <= mode_nxt;
    end
  end

  // ---- quotients
  logic [F:0] q1_w, q2_w;
  logic       z1_w, z2_w;

  cpt_div #(.NW(NW), .FB(F)) u_div1 (
    .clk(clk), .en(en), .num(n1_r), .den(d1_r), .q(q1_w), .dz(z1_w));
  cpt_div #(.NW(NW), .FB(F)) u_div2 (
    .clk(clk), .en(en), .num(n2_r), .den(d2_r), .q(q2_w), .dz(z2_w));

  logic [$bits(mode_t)-1:0] mode_q;
  mode_t                    mode_d;

  cpt_pipe #(.WIDTH($bits(mode_t)), .DEPTH(DL)) u_mode_dly (
    .clk(clk), .en(en), .d(mode_r), .q(mode_q));

  assign mode_d = mode_t'(mode_q);

  logic [F:0] sq_r, tq_r;
  logic       flag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (mode_d)
        MD_S_ONLY: begin
          sq_r <= q1_w;
          tq_r <= '0;
        end
        MD_T_ONLY: begin
          sq_r <= '0;
          tq_r <= q1_w;
        end
        MD_BOTH: begin
          sq_r <= q1_w;
          tq_r <= q2_w;
        end
        MD_EDGE: begin
          sq_r <= q1_w;
          tq_r <= {1'b1, {F{1'b0}}} - q1_w;
        end
        default: begin
          sq_r <= '0;
          tq_r <= '0;
        end
      endcase
      flag_r <= z1_w || ((mode_d == MD_BOTH) && z2_w);
    end
  end

  // ---- A + s*E0 + t*E1
  logic [6*EW-1:0] edge_q;

  cpt_pipe #(.WIDTH(6*EW), .DEPTH(D_E)) u_edge_dly (
    .clk(clk), .en(en),
    .d({e0_r[0], e0_r[1], e0_r[2], e1_r[0], e1_r[1], e1_r[2]}),
    .q(edge_q));

  logic [3*W-1:0] va_q;

  cpt_pipe #(.WIDTH(3*W), .DEPTH(D_VA)) u_va_dly (
    .clk(clk), .en(en), .d({va_r[0], va_r[1], va_r[2]}), .q(va_q));

  logic signed [F+1:0]  sq_s, tq_s;
  logic signed [MW-1:0] ps_w [3], pt_w [3];
  logic signed [AW-1:0] acc_r [3];
  logic                 flag6_w;
  logic [W-1:0]         near_r [3];
  logic                 deg_r;

  assign sq_s = signed'({1'b0, sq_r});
  assign tq_s = signed'({1'b0, tq_r});

  for (genvar k = 0; k < 3; k++) begin : g_out
    logic signed [EW-1:0] e0d, e1d;
    logic signed [W-1:0]  vad;
    logic signed [VW-1:0] sum;
    logic [VW-W:0]        top;

    assign e0d = signed'(edge_q[(6-k)*EW-1 -: EW]);
    assign e1d = signed'(edge_q[(3-k)*EW-1 -: EW]);
    assign vad = signed'(va_q[(3-k)*W-1 -: W]);

    cpt_mul #(.AW(EW), .BW(F+2)) u_ms (
      .clk(clk), .en(en), .a(e0d), .b(sq_s), .p(ps_w[k]));
    cpt_mul #(.AW(EW), .BW(F+2)) u_mt (
      .clk(clk), .en(en), .a(e1d), .b(tq_s), .p(pt_w[k]));

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k] <= AW'(ps_w[k]) + AW'(pt_w[k]) + signed'(RND);
      end
    end

    // Rounded offset plus the vertex; saturate when the sign bit and the
    // bits above it disagree.
    assign sum = VW'(signed'(acc_r[k][AW-1:F])) + VW'(vad);
    assign top = sum[VW-1:W-1];

    always_ff @(posedge clk) begin
      if (en) begin
        if ((top == '0) || (top == '1)) begin
          near_r[k] <= sum[W-1:0];
        end else if (sum[VW-1]) begin
          near_r[k] <= {1'b1, {(W-1){1'b0}}};
        end else begin
          near_r[k] <= {1'b0, {(W-1){1'b1}}};
        end
      end
    end
  end

  // The flag follows the output multipliers, the sum rank and the saturation rank.
  cpt_pipe #(.WIDTH(1), .DEPTH(ML + 1)) u_flag_dly (
    .clk(clk), .en(en), .d(flag_r), .q(flag6_w));

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r <= flag6_w;
    end
  end

  assign out_valid      = vld_r[LAT-1];
  assign out_near_x     = signed'(near_r[0]);
  assign out_near_y     = signed'(near_r[1]);
  assign out_near_z     = signed'(near_r[2]);
  assign out_degenerate = deg_r;

endmodule : closest_point_on_triangle

`default_nettype wire
